// ----- hdl/qalp_pkg.sv -----
// Shared types and constants for the quoted argument line parser.
package qalp_pkg;

   localparam logic [7:0] ChSpace     = 8'h20;
   localparam logic [7:0] ChBackslash = 8'h5C;
   localparam logic [7:0] ChQuote     = 8'h22;
   localparam logic [7:0] ChLowerN    = 8'h6E;
   localparam logic [7:0] ChLowerR    = 8'h72;
   localparam logic [7:0] ChLf        = 8'h0A;
   localparam logic [7:0] ChCr        = 8'h0D;

   localparam logic [2:0] KindCmdByte   = 3'd0;
   localparam logic [2:0] KindCmdEnd    = 3'd1;
   localparam logic [2:0] KindParamByte = 3'd2;
   localparam logic [2:0] KindParamEnd  = 3'd3;
   localparam logic [2:0] KindLineEnd   = 3'd4;

   localparam int FifoDepth  = 4;
   localparam int PtrWidth   = $clog2(FifoDepth);
   localparam int CountWidth = PtrWidth + 1;

   typedef struct packed {
      logic past_command;
      logic inside_quotes;
      logic escape_pending;
   } state_type;

   typedef struct packed {
      logic [2:0] kind;
      logic [7:0] out_byte;
      logic       unterminated;
      logic       last_of_run;
   } result_type;

   typedef struct packed {
      logic [1:0] count;
      result_type first;
      result_type second;
      state_type  next_state;
   } decode_type;

endpackage

// ----- hdl/qalp_decode.sv -----
// Per-byte decode: parser state and one input byte to up to two result words.
module qalp_decode (
   input  qalp_pkg::state_type  state,
   input  logic [7:0]           line_byte,
   input  logic                 end_of_line,
   output qalp_pkg::decode_type dec
);
   import qalp_pkg::*;

   logic       main_valid;
   result_type main_res;
   result_type eol_res;
   state_type  st;

   always_comb begin
      st         = state;
      main_valid = 1'b0;
      main_res   = '0;
      if (!state.past_command) begin
         main_valid = 1'b1;
         if (line_byte == ChSpace) begin
            main_res.kind   = KindCmdEnd;
            st.past_command = 1'b1;
         end else begin
            main_res.kind     = KindCmdByte;
            main_res.out_byte = line_byte;
         end
      end else if (state.escape_pending) begin
         st.escape_pending = 1'b0;
         if (state.inside_quotes) begin
            main_res.kind = KindParamByte;
            main_valid    = 1'b1;
            case (line_byte)
               ChBackslash: main_res.out_byte = ChBackslash;
               ChQuote:     main_res.out_byte = ChQuote;
               ChLowerN:    main_res.out_byte = ChLf;
               ChLowerR:    main_res.out_byte = ChCr;
               default:     main_valid        = 1'b0;
            endcase
         end
      end else if (line_byte == ChBackslash) begin
         st.escape_pending = 1'b1;
      end else if (line_byte == ChQuote) begin
         if (state.inside_quotes) begin
            main_valid       = 1'b1;
            main_res.kind    = KindParamEnd;
            st.inside_quotes = 1'b0;
         end else begin
            st.inside_quotes = 1'b1;
         end
      end else if (state.inside_quotes) begin
         main_valid        = 1'b1;
         main_res.kind     = KindParamByte;
         main_res.out_byte = line_byte;
      end

      eol_res              = '0;
      eol_res.kind         = KindLineEnd;
      eol_res.unterminated = st.inside_quotes;
      eol_res.last_of_run  = 1'b1;

      dec            = '0;
      dec.next_state = end_of_line ? state_type'('0) : st;
      if (main_valid && end_of_line) begin
         dec.count  = 2'd2;
         dec.first  = main_res;
         dec.second = eol_res;
      end else if (main_valid) begin
         dec.count             = 2'd1;
         dec.first             = main_res;
         dec.first.last_of_run = 1'b1;
      end else if (end_of_line) begin
         dec.count = 2'd1;
         dec.first = eol_res;
      end
   end

endmodule

// ----- hdl/qalp_result_fifo.sv -----
// Small result queue: takes up to two words per cycle, hands out one.
module qalp_result_fifo (
   input  logic                 clock,
   input  logic                 reset,
   input  logic [1:0]           push_count,
   input  qalp_pkg::result_type push_first,
   input  qalp_pkg::result_type push_second,
   input  logic                 pop,
   output qalp_pkg::result_type head,
   output logic                 not_empty,
   output logic                 room
);
   import qalp_pkg::*;

   result_type            entries_ff [FifoDepth];
   logic [PtrWidth-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PtrWidth-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CountWidth-1:0] count_ff, count_in;
   logic [PtrWidth-1:0]   wr_next;

   assign wr_next   = wr_ptr_ff + PtrWidth'(1);
   assign head      = entries_ff[rd_ptr_ff];
   assign not_empty = count_ff != '0;
   assign room      = count_ff <= CountWidth'(FifoDepth - 2);

   always_comb begin
      wr_ptr_in = wr_ptr_ff + PtrWidth'(push_count);
      rd_ptr_in = rd_ptr_ff + PtrWidth'(pop);
      count_in  = count_ff + CountWidth'(push_count) - CountWidth'(pop);
   end

   always_ff @(posedge clock) begin
      if (push_count != 2'd0) begin
         entries_ff[wr_ptr_ff] <= push_first;
      end
      if (push_count == 2'd2) begin
         entries_ff[wr_next] <= push_second;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      count_ff <= CountWidth'(FifoDepth))
      else $error("result queue overflow");

   assert property (@(posedge clock) disable iff (reset)
      pop |-> not_empty)
      else $error("pop from empty result queue");

   assert property (@(posedge clock) disable iff (reset)
      (push_count != 2'd0) |-> room)
      else $error("push without room");

endmodule

// ----- hdl/quoted_argument_line_parser.sv -----
// Top level of the quoted argument line parser.
// Splits a command line, one byte per accepted word, into command bytes, a
// command end, decoded parameter bytes and parameter ends, plus a line-end word
// after the byte marked end_of_line. A byte is decoded in the cycle it is
// accepted and its zero to two result words enter a four-word queue; one byte
// is taken every cycle while the queue has room for two words, and one result
// word leaves per cycle unless rsp_stall is high; two results leave in order.
module quoted_argument_line_parser (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_line_byte,
   input  logic       req_end_of_line,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [2:0] rsp_result_kind,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_unterminated,
   output logic       rsp_last_of_run
);
   import qalp_pkg::*;

   state_type  state_ff, state_in;
   decode_type dec;
   result_type head;
   logic       req_accept;
   logic       room;
   logic       not_empty;

   qalp_decode u_decode (
      .state       (state_ff),
      .line_byte   (req_line_byte),
      .end_of_line (req_end_of_line),
      .dec         (dec)
   );

   assign req_stall  = !room;
   assign req_accept = req_valid && room;
   assign state_in   = req_accept ? dec.next_state : state_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else begin
         state_ff <= state_in;
      end
   end

   qalp_result_fifo u_fifo (
      .clock       (clock),
      .reset       (reset),
      .push_count  (req_accept ? dec.count : 2'd0),
      .push_first  (dec.first),
      .push_second (dec.second),
      .pop         (not_empty && !rsp_stall),
      .head        (head),
      .not_empty   (not_empty),
      .room        (room)
   );

   assign rsp_valid        = not_empty;
   assign rsp_result_kind  = head.kind;
   assign rsp_out_byte     = head.out_byte;
   assign rsp_unterminated = head.unterminated;
   assign rsp_last_of_run  = head.last_of_run;

   assert property (@(posedge clock) disable iff (reset)
      req_accept && req_end_of_line |=> state_ff == state_type'('0))
      else $error("state not cleared after line end");

   assert property (@(posedge clock) disable iff (reset)
      (state_ff.inside_quotes || state_ff.escape_pending) |-> state_ff.past_command)
      else $error("parameter state while still in command");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_result_kind == KindLineEnd |-> rsp_last_of_run)
      else $error("line end word not last of run");

endmodule

// ----- test/tb_top.sv -----
// Testbench for the quoted argument line parser: directed and random lines, checked in order.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import qalp_pkg::*;

   typedef struct packed {
      logic [7:0] ch;
      logic       eol;
   } line_word_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [7:0] req_line_byte = 8'h00;
   logic       req_end_of_line = 1'b0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic [2:0] rsp_result_kind;
   logic [7:0] rsp_out_byte;
   logic       rsp_unterminated;
   logic       rsp_last_of_run;

   line_word_type bytes_to_send[$];
   logic [7:0]    line_buf[$];
   result_type    tokens_due[$];

   logic cmd_done = 1'b0;
   logic in_param = 1'b0;
   logic esc_pending = 1'b0;

   bit in_taken = 1'b0;
   bit hold_req = 1'b0;
   int hold_left = 0;
   int send_idle_pct = 0;
   int stall_pct = 0;
   int words_queued = 0;
   int mismatch_count = 0;

   quoted_argument_line_parser dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_line_byte   (req_line_byte),
      .req_end_of_line (req_end_of_line),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_result_kind (rsp_result_kind),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_unterminated(rsp_unterminated),
      .rsp_last_of_run (rsp_last_of_run)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   task automatic report_mismatch(string what);
      mismatch_count++;
      $display("MISMATCH at %0t: %s", $realtime, what);
   endtask

   function automatic result_type make_token(logic [2:0] k, logic [7:0] v, logic u);
      result_type r;
      r.kind = k;
      r.out_byte = v;
      r.unterminated = u;
      r.last_of_run = 1'b0;
      return r;
   endfunction

   // Tokens caused by one accepted byte; updates the parser state.
   function automatic void decode_byte(logic [7:0] b, logic eol);
      result_type res[2];
      int n;
      n = 0;
      if (!cmd_done) begin
         if (b == ChSpace) begin
            res[n] = make_token(KindCmdEnd, 8'h00, 1'b0);
            n++;
            cmd_done = 1'b1;
         end else begin
            res[n] = make_token(KindCmdByte, b, 1'b0);
            n++;
         end
      end else if (esc_pending) begin
         esc_pending = 1'b0;
         if (in_param) begin
            case (b)
               ChBackslash, ChQuote: begin
                  res[n] = make_token(KindParamByte, b, 1'b0);
                  n++;
               end
               ChLowerN: begin
                  res[n] = make_token(KindParamByte, ChLf, 1'b0);
                  n++;
               end
               ChLowerR: begin
                  res[n] = make_token(KindParamByte, ChCr, 1'b0);
                  n++;
               end
               default: ;
            endcase
         end
      end else if (b == ChBackslash) begin
         esc_pending = 1'b1;
      end else if (b == ChQuote) begin
         if (in_param) begin
            res[n] = make_token(KindParamEnd, 8'h00, 1'b0);
            n++;
         end
         in_param = !in_param;
      end else if (in_param) begin
         res[n] = make_token(KindParamByte, b, 1'b0);
         n++;
      end
      if (eol) begin
         res[n] = make_token(KindLineEnd, 8'h00, in_param);
         n++;
         cmd_done = 1'b0;
         in_param = 1'b0;
         esc_pending = 1'b0;
      end
      if (n > 0) res[n - 1].last_of_run = 1'b1;
      for (int i = 0; i < n; i++) tokens_due = {tokens_due, res[i]};
   endfunction

   function automatic logic [7:0] plain_char();
      logic [7:0] b;
      do b = 8'($urandom_range(255)); while (b == ChQuote || b == ChBackslash);
      return b;
   endfunction

   function automatic logic [7:0] cmd_char();
      logic [7:0] b;
      do b = 8'($urandom_range(255)); while (b == ChSpace);
      return b;
   endfunction

   function automatic logic [7:0] escape_char();
      case ($urandom_range(4))
         0: return ChLowerN;
         1: return ChLowerR;
         2: return ChBackslash;
         3: return ChQuote;
         default: return 8'($urandom_range(255));
      endcase
   endfunction

   task automatic add_byte(logic [7:0] b, logic eol);
      line_word_type w;
      w.ch = b;
      w.eol = eol;
      bytes_to_send = {bytes_to_send, w};
      words_queued++;
   endtask

   task automatic flush_line();
      for (int i = 0; i < line_buf.size(); i++) add_byte(line_buf[i], i == line_buf.size() - 1);
      line_buf.delete();
   endtask

   task automatic build_good_line();
      int n_cmd;
      int n_par;
      int n_chr;
      n_cmd = $urandom_range(6);
      for (int i = 0; i < n_cmd; i++) line_buf = {line_buf, cmd_char()};
      line_buf = {line_buf, ChSpace};
      n_par = $urandom_range(4);
      for (int p = 0; p < n_par; p++) begin
         if ($urandom_range(3) == 0) line_buf = {line_buf, plain_char()};
         line_buf = {line_buf, ChQuote};
         n_chr = $urandom_range(8);
         for (int c = 0; c < n_chr; c++) begin
            if ($urandom_range(4) == 0) begin
               line_buf = {line_buf, ChBackslash};
               line_buf = {line_buf, escape_char()};
            end else begin
               line_buf = {line_buf, plain_char()};
            end
         end
         // occasionally leave the last parameter open
         if (p < n_par - 1 || $urandom_range(4) != 0) line_buf = {line_buf, ChQuote};
      end
      if ($urandom_range(9) == 0) line_buf = {line_buf, ChBackslash};
   endtask

   task automatic build_noise_line();
      int len;
      len = $urandom_range(1, 12);
      for (int i = 0; i < len; i++) begin
         case ($urandom_range(5))
            0: line_buf = {line_buf, ChQuote};
            1: line_buf = {line_buf, ChBackslash};
            2: line_buf = {line_buf, ChSpace};
            3: line_buf = {line_buf, ChLowerN};
            default: line_buf = {line_buf, 8'($urandom_range(255))};
         endcase
      end
   endtask

   always @(negedge clock) begin : byte_driver
      line_word_type w;
      if (!req_valid || in_taken) begin
         if (!reset && bytes_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            w = bytes_to_send.pop_front();
            req_valid <= 1'b1;
            req_line_byte <= w.ch;
            req_end_of_line <= w.eol;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      if (hold_req) begin
         hold_req = 1'b0;
         hold_left = 300;
      end
      if (hold_left > 0) begin
         hold_left = hold_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   always @(posedge clock) begin : result_monitor
      result_type want;
      in_taken = !reset && req_valid && !req_stall;
      if (in_taken) decode_byte(req_line_byte, req_end_of_line);
      if (!reset && rsp_valid && !rsp_stall) begin
         if (tokens_due.size() == 0) begin
            report_mismatch($sformatf("unexpected word kind %0d byte %h",
                                      rsp_result_kind, rsp_out_byte));
         end else begin
            want = tokens_due.pop_front();
            if (rsp_result_kind !== want.kind)
               report_mismatch($sformatf("kind %0d, want %0d", rsp_result_kind, want.kind));
            if (rsp_out_byte !== want.out_byte)
               report_mismatch($sformatf("byte %h, want %h", rsp_out_byte, want.out_byte));
            if (rsp_unterminated !== want.unterminated)
               report_mismatch($sformatf("unterminated %b, want %b",
                                         rsp_unterminated, want.unterminated));
            if (rsp_last_of_run !== want.last_of_run)
               report_mismatch($sformatf("last_of_run %b, want %b",
                                         rsp_last_of_run, want.last_of_run));
         end
      end
   end

   initial begin : stimulus
      int target;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // extremes, every escape, escape outside quotes, unterminated parameter
      add_byte(8'hFF, 1'b0);
      add_byte(8'h00, 1'b0);
      add_byte(ChSpace, 1'b0);
      add_byte(ChQuote, 1'b0);
      add_byte(8'h80, 1'b0);
      add_byte(ChSpace, 1'b0);
      add_byte(ChBackslash, 1'b0);
      add_byte(ChLowerN, 1'b0);
      add_byte(ChBackslash, 1'b0);
      add_byte(ChLowerR, 1'b0);
      add_byte(ChBackslash, 1'b0);
      add_byte(ChBackslash, 1'b0);
      add_byte(ChBackslash, 1'b0);
      add_byte(ChQuote, 1'b0);
      add_byte(ChBackslash, 1'b0);
      add_byte(8'h78, 1'b0);
      add_byte(ChQuote, 1'b0);
      add_byte(ChBackslash, 1'b0);
      add_byte(ChQuote, 1'b0);
      add_byte(8'h7A, 1'b0);
      add_byte(ChQuote, 1'b0);
      add_byte(8'h71, 1'b1);
      // line end inside the command, on the first space, with an escape pending
      add_byte(8'h61, 1'b1);
      add_byte(ChSpace, 1'b1);
      add_byte(ChSpace, 1'b0);
      add_byte(ChBackslash, 1'b1);

      for (int phase = 0; phase < 5; phase++) begin
         @(posedge clock);
         case (phase)
            0: begin
               send_idle_pct = 0;
               stall_pct = 0;
            end
            1: begin
               send_idle_pct = 51;
               stall_pct = 0;
            end
            2: begin
               send_idle_pct = 0;
               stall_pct = 51;
            end
            3: begin
               send_idle_pct = 27;
               stall_pct = 27;
            end
            default: begin
               send_idle_pct = 0;
               stall_pct = 0;
               hold_req = 1'b1;
            end
         endcase
         target = words_queued + 350;
         while (words_queued < target) begin
            if ($urandom_range(4) == 0) build_noise_line();
            else build_good_line();
            flush_line();
         end
         while (bytes_to_send.size() != 0 || req_valid || tokens_due.size() != 0)
            @(negedge clock);
      end

      repeat (10) @(negedge clock);
      if (mismatch_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

   initial begin
      #4000000;
      $display("Verification failed");
      $finish;
   end

endmodule

// ----- files.f -----
hdl/qalp_pkg.sv
hdl/qalp_decode.sv
hdl/qalp_result_fifo.sv
hdl/quoted_argument_line_parser.sv
test/tb_top.sv
